// File: rtl/u5ve_pkg.sv
// Shared types, mode codes and word transforms for the UNSIGNED5 varint encoder.
// No dependencies; every other file of the block but the checker imports this package.
package u5ve_pkg;

   // Mode codes carried on the func field.
   localparam logic [2:0] FUNC_UINT   = 3'd0;
   localparam logic [2:0] FUNC_SINT   = 3'd1;
   localparam logic [2:0] FUNC_FLOAT  = 3'd2;
   localparam logic [2:0] FUNC_LONG   = 3'd3;
   localparam logic [2:0] FUNC_DOUBLE = 3'd4;

   // Coding limits of one 32-bit word.
   localparam int unsigned MAX_WORD_BYTES = 5;
   localparam logic [31:0] LOW_LIMIT      = 32'd192;
   localparam logic [31:0] LIMIT_SHIFTED  = 32'd3;

   // Masks of the bit reversal network.
   localparam logic [31:0] MASK_ODD1  = 32'h5555_5555;
   localparam logic [31:0] MASK_ODD2  = 32'h3333_3333;
   localparam logic [31:0] MASK_ODD4  = 32'h0f0f_0f0f;
   localparam logic [31:0] MASK_BYTE1 = 32'h0000_ff00;

   // One word's code: up to five bytes, count from 1 to 5.
   typedef struct packed {
      logic [MAX_WORD_BYTES-1:0][7:0] code;
      logic [2:0]                     len;
   } word_code_type;

   // The one or two words an item is coded as.
   typedef struct packed {
      logic [31:0] first;
      logic [31:0] second;
      logic        two_words;
   } word_pair_type;

   function automatic logic [31:0] zigzag32(input logic [31:0] v);
      zigzag32 = {v[30:0], 1'b0} ^ {32{v[31]}};
   endfunction

   function automatic logic [31:0] bit_reverse32(input logic [31:0] v);
      logic [31:0] t;
      t = ((v & MASK_ODD1) << 1) | ((v >> 1) & MASK_ODD1);
      t = ((t & MASK_ODD2) << 2) | ((t >> 2) & MASK_ODD2);
      t = ((t & MASK_ODD4) << 4) | ((t >> 4) & MASK_ODD4);
      t = (t << 24) | ((t & MASK_BYTE1) << 8) | ((t >> 8) & MASK_BYTE1) | (t >> 24);
      bit_reverse32 = t;
   endfunction

endpackage

// File: rtl/u5ve_mode_map.sv
// Mode decode: maps one registered item to the one or two words to be coded.
// Depends on u5ve_pkg for mode codes and the zigzag and bit reversal functions.
module u5ve_mode_map (
   input  logic [2:0]             func,
   input  logic [63:0]            value,
   output u5ve_pkg::word_pair_type words
);
   import u5ve_pkg::*;

   logic [31:0] lo;
   logic [31:0] hi;

   assign lo = value[31:0];
   assign hi = value[63:32];

   always_comb begin
      words.first     = lo;
      words.second    = hi;
      words.two_words = 1'b0;
      // Unused mode codes fall back to plain unsigned coding.
      unique case (func)
         FUNC_SINT: begin
            words.first = zigzag32(lo);
         end
         FUNC_FLOAT: begin
            words.first = bit_reverse32(lo);
         end
         FUNC_LONG: begin
            words.first     = zigzag32(lo);
            words.second    = zigzag32(hi);
            words.two_words = 1'b1;
         end
         FUNC_DOUBLE: begin
            words.first     = bit_reverse32(hi);
            words.second    = bit_reverse32(lo);
            words.two_words = 1'b1;
         end
         default: begin
            words.first = lo;
         end
      endcase
   end

endmodule

// File: rtl/u5ve_word_coder.sv
// Codes one 32-bit word into its UNSIGNED5 bytes and byte count.
// Depends on u5ve_pkg for the word code type and coding limits.
module u5ve_word_coder (
   input  logic [31:0]             word,
   output u5ve_pkg::word_code_type result
);
   import u5ve_pkg::*;

   logic [MAX_WORD_BYTES-1:0][31:0] rest;
   logic [MAX_WORD_BYTES-2:0]       cont;

   // Since 192 is a multiple of 64, subtracting it leaves the low six bits alone,
   // and (w - 192) >> 6 equals (w >> 6) - 3.
   always_comb begin
      rest[0] = word;
      for (int i = 0; i < MAX_WORD_BYTES - 1; i++) begin
         cont[i]        = rest[i] >= LOW_LIMIT;
         rest[i+1]      = (rest[i] >> 6) - LIMIT_SHIFTED;
         result.code[i] = cont[i] ? {2'b11, rest[i][5:0]} : rest[i][7:0];
      end
      result.code[MAX_WORD_BYTES-1] = rest[MAX_WORD_BYTES-1][7:0];
   end

   always_comb begin
      priority if (!cont[0]) begin
         result.len = 3'd1;
      end else if (!cont[1]) begin
         result.len = 3'd2;
      end else if (!cont[2]) begin
         result.len = 3'd3;
      end else if (!cont[3]) begin
         result.len = 3'd4;
      end else begin
         result.len = 3'd5;
      end
   end

endmodule

// File: rtl/u5ve_byte_sequencer.sv
// Result buffer: holds the coded words of one item and hands out one byte per word.
// Depends on u5ve_pkg for the word code type.
module u5ve_byte_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_valid,
   output logic                    load_ready,
   input  u5ve_pkg::word_code_type load_first,
   input  u5ve_pkg::word_code_type load_second,
   input  logic                    load_two,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_code_byte,
   output logic                    rsp_last
);
   import u5ve_pkg::*;

   logic          valid_ff, valid_in;
   logic          sel_ff, sel_in;
   logic [2:0]    pos_ff, pos_in;
   logic          two_ff, two_in;
   word_code_type first_ff, first_in;
   word_code_type second_ff, second_in;

   logic [2:0] cur_len;
   logic       end_of_word;
   logic       fire;

   assign cur_len       = sel_ff ? second_ff.len : first_ff.len;
   assign end_of_word   = pos_ff == (cur_len - 3'd1);
   assign rsp_valid     = valid_ff;
   assign rsp_last      = end_of_word && (sel_ff || !two_ff);
   assign rsp_code_byte = sel_ff ? second_ff.code[pos_ff] : first_ff.code[pos_ff];
   assign fire          = valid_ff && rsp_ready;
   // A new item may enter while the last byte of the current one leaves.
   assign load_ready    = !valid_ff || (fire && rsp_last);

   always_comb begin
      valid_in  = valid_ff;
      sel_in    = sel_ff;
      pos_in    = pos_ff;
      two_in    = two_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (load_valid && load_ready) begin
         valid_in  = 1'b1;
         sel_in    = 1'b0;
         pos_in    = 3'd0;
         two_in    = load_two;
         first_in  = load_first;
         second_in = load_second;
      end else if (fire) begin
         if (rsp_last) begin
            valid_in = 1'b0;
         end else if (end_of_word) begin
            sel_in = 1'b1;
            pos_in = 3'd0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
         pos_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      two_ff    <= two_in;
      first_ff  <= first_in;
      second_ff <= second_in;
   end

endmodule

// File: rtl/unsigned5_varint_encoder_core.sv
// Top level of the UNSIGNED5 varint encoder: input register, mode decode, two word
// coders and the result buffer. Depends on u5ve_pkg and the u5ve_* submodules.
//
// Usage:
//   The request channel (req_valid, req_ready, req_func, req_value) takes one word per
//   item: a mode and a 64-bit value. The response channel (rsp_valid, rsp_ready,
//   rsp_code_byte, rsp_last) returns the UNSIGNED5 code of that item one byte per
//   word, from 1 to 10 bytes, with rsp_last high on the final byte of the item.
//   Modes 3 and 4 code two 32-bit words back to back; the other modes code one.
//
//   Flow: an accepted item goes into the input register and moves on into the result
//   buffer once that is free, where its first byte shows. An item holds the result
//   buffer until its last byte goes; the single byte port hands out one byte per cycle
//   while rsp_ready is high, and one-byte codes then sustain one item per cycle.
//   The input register keeps taking the next item while the buffer still drains the
//   current one, and the buffer takes that next item in the cycle its last byte goes.
//
//   Reset is synchronous and active high; it empties both the input register and the
//   result buffer. When the receiver stalls, the current byte holds steady on the
//   response ports, the input register fills, and req_ready then drops until the
//   buffer frees up again. There is no configuration and no state between items.
module unsigned5_varint_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_code_byte,
   output logic        rsp_last
);
   import u5ve_pkg::*;

   // Input register stage.
   logic        hold_valid_ff, hold_valid_in;
   logic [2:0]  func_ff, func_in;
   logic [63:0] value_ff, value_in;

   word_pair_type words;
   word_code_type first_code;
   word_code_type second_code;
   logic          seq_ready;

   // The input register may refill in the same cycle it hands its item on.
   assign req_ready = !hold_valid_ff || seq_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      func_in       = func_ff;
      value_in      = value_ff;
      if (req_valid && req_ready) begin
         hold_valid_in = 1'b1;
         func_in       = req_func;
         value_in      = req_value;
      end else if (seq_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      value_ff <= value_in;
   end

   // Coding logic between the input register and the result buffer.
   u5ve_mode_map u_mode_map (
      .func  (func_ff),
      .value (value_ff),
      .words (words)
   );

   u5ve_word_coder u_coder_first (
      .word   (words.first),
      .result (first_code)
   );

   u5ve_word_coder u_coder_second (
      .word   (words.second),
      .result (second_code)
   );

   u5ve_byte_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .load_valid    (hold_valid_ff),
      .load_ready    (seq_ready),
      .load_first    (first_code),
      .load_second   (second_code),
      .load_two      (words.two_words),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last      (rsp_last)
   );

endmodule

// File: rtl/u5ve_checker.sv
// Port-level checker for the UNSIGNED5 varint encoder, bound to its top level.
// Depends only on the top level's ports.
module u5ve_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_code_byte,
   input logic       rsp_last
);

   // A stalled response word holds its byte and marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_byte) && $stable(rsp_last))
      else $error("stalled response word changed");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // With the result buffer empty the block must take a new item.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request stalled with empty result buffer");

   // The final byte leaving frees room for the next item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |-> req_ready)
      else $error("request stalled while last byte leaves");

endmodule

bind unsigned5_varint_encoder_core u5ve_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_code_byte (rsp_code_byte),
   .rsp_last      (rsp_last)
);

// File: tb/tb.sv
// Self-checking bench for unsigned5_varint_encoder_core: directed and random requests,
// an in-bench predictor of the UNSIGNED5 byte code and an in-order check of every byte.
// Depends on u5ve_pkg for the mode codes and coding limits, and on the encoder RTL.
module tb;
   import u5ve_pkg::*;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] value;
   } enc_request_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last;
   } code_entry_type;

   // Idling pattern of the current phase of the run.
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [63:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_code_byte;
   logic        rsp_last;

   // Requests waiting to be driven, and the code bytes still owed by the block, oldest first.
   enc_request_type request_queue[$];
   code_entry_type  expected_bytes[$];

   idle_mode_type idle_mode = IDLE_NONE;
   logic          req_taken = 1'b0;
   logic          hold_off = 1'b0;
   int            accepted_requests = 0;
   int            errors = 0;

   unsigned5_varint_encoder_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last      (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Zigzag: small magnitudes of either sign become small unsigned numbers.
   function automatic logic [31:0] zigzag_map(input logic [31:0] v);
      return v[31] ? ~(v << 1) : (v << 1);
   endfunction

   function automatic logic [31:0] reverse_bits(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) r[i] = v[31 - i];
      return r;
   endfunction

   // Appends the code of one 32-bit word. At most four continuation bytes are produced;
   // whatever is left after them goes out as the final byte, even when it is 192 or more.
   function automatic void push_word_code(input logic [31:0] w);
      int unsigned high_bytes;
      code_entry_type entry;
      high_bytes = 0;
      entry.last = 1'b0;
      while (w >= LOW_LIMIT && high_bytes < MAX_WORD_BYTES - 1) begin
         w = w - LOW_LIMIT;
         entry.code_byte = LOW_LIMIT[7:0] + {2'b00, w[5:0]};
         expected_bytes.push_back(entry);
         w = w >> 6;
         high_bytes++;
      end
      entry.code_byte = w[7:0];
      expected_bytes.push_back(entry);
   endfunction

   // Works out the whole byte code of one accepted request. Undefined modes code the
   // low word unsigned, and single-word modes never look at the high half of the value.
   function automatic void predict_code(input logic [2:0] func, input logic [63:0] value);
      case (func)
         FUNC_SINT: begin
            push_word_code(zigzag_map(value[31:0]));
         end
         FUNC_FLOAT: begin
            push_word_code(reverse_bits(value[31:0]));
         end
         FUNC_LONG: begin
            push_word_code(zigzag_map(value[31:0]));
            push_word_code(zigzag_map(value[63:32]));
         end
         FUNC_DOUBLE: begin
            push_word_code(reverse_bits(value[63:32]));
            push_word_code(reverse_bits(value[31:0]));
         end
         default: begin
            push_word_code(value[31:0]);
         end
      endcase
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
   endfunction

   // A word of random content, biased so that codes of every length show up: small
   // values, values near all ones (small negatives), random widths and full random bits.
   function automatic logic [31:0] rand_word();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 3))
         0: r = 32'($urandom_range(0, 400));
         1: r = r >> $urandom_range(0, 31);
         2: r = ~32'($urandom_range(0, 400));
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_request(input logic [2:0] func, input logic [63:0] value);
      enc_request_type req;
      req.func = func;
      req.value = value;
      request_queue.push_back(req);
   endtask

   task automatic wait_drained();
      while (request_queue.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   // Driver. Inputs change on the falling edge only. A request stays on the ports until
   // the rising edge that takes it; only then is the next one, or a gap, put up. The
   // receiver side stalls at random or for the long hold-off below.
   always @(negedge clock) begin
      enc_request_type next_req;
      int send_gap_pct;
      int stall_pct;
      case (idle_mode)
         IDLE_SENDER: begin
            send_gap_pct = 76;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_gap_pct = 0;
            stall_pct = 76;
         end
         IDLE_BOTH: begin
            send_gap_pct = 32;
            stall_pct = 32;
         end
         default: begin
            send_gap_pct = 0;
            stall_pct = 0;
         end
      endcase
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               next_req = request_queue.pop_front();
               req_valid <= 1'b1;
               req_func <= next_req.func;
               req_value <= next_req.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Monitor. Both handshakes are sampled on the rising edge. A request taken here is
   // predicted at once; its first byte cannot show up before the next edge, so the
   // expectation is always in place ahead of the byte.
   always @(posedge clock) begin
      code_entry_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_code(req_func, req_value);
            accepted_requests <= accepted_requests + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("code byte %0d (last %0b) with no byte expected", rsp_code_byte,
                      rsp_last);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_code_byte !== want.code_byte) begin
                  $error("code_byte: expected %0d, got %0d", want.code_byte, rsp_code_byte);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  errors++;
               end
            end
         end
      end
   end

   // Back-pressure: once the first random phase is under way, the receiver holds off
   // for a long stretch while the sender keeps offering words. The result buffer and
   // the input register fill up, so req_ready has to drop and the block must lose
   // nothing when the receiver comes back.
   initial begin
      while (accepted_requests < 60) @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Stimulus: a directed set first, then four random phases with different idling.
   initial begin
      // Unsigned: single-byte edge, first two-byte code, and the longest code whose
      // fifth byte carries the leftover as is. High half must be ignored.
      queue_request(FUNC_UINT, 64'd0);
      queue_request(FUNC_UINT, 64'd191);
      queue_request(FUNC_UINT, 64'd192);
      queue_request(FUNC_UINT, 64'd255);
      queue_request(FUNC_UINT, 64'h0000_0000_0000_30bf);
      queue_request(FUNC_UINT, 64'h0000_0000_ffff_ffff);
      queue_request(FUNC_UINT, 64'hffff_ffff_0000_0005);
      // Signed: zero, extremes of both signs, minus one.
      queue_request(FUNC_SINT, 64'd0);
      queue_request(FUNC_SINT, 64'h0000_0000_7fff_ffff);
      queue_request(FUNC_SINT, 64'h0000_0000_8000_0000);
      queue_request(FUNC_SINT, 64'hffff_ffff_ffff_ffff);
      // Float bits: the reversal moves bit 0 to the top.
      queue_request(FUNC_FLOAT, 64'd0);
      queue_request(FUNC_FLOAT, 64'd1);
      queue_request(FUNC_FLOAT, 64'h0000_0000_ffff_ffff);
      queue_request(FUNC_FLOAT, 64'hdead_beef_0000_0003);
      // Two-word modes, including the longest possible code of ten bytes.
      queue_request(FUNC_LONG, 64'd0);
      queue_request(FUNC_LONG, 64'hffff_ffff_ffff_ffff);
      queue_request(FUNC_LONG, 64'h8000_0000_7fff_ffff);
      queue_request(FUNC_DOUBLE, 64'd0);
      queue_request(FUNC_DOUBLE, 64'hffff_ffff_ffff_ffff);
      queue_request(FUNC_DOUBLE, 64'h0000_0001_8000_0000);
      // Undefined modes behave as unsigned.
      queue_request(3'd5, 64'h1234_5678_ffff_ffff);
      queue_request(3'd6, 64'hffff_ffff_0000_00c0);
      queue_request(3'd7, 64'h0000_0000_0000_00bf);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         idle_mode = idle_mode_type'(phase);
         for (int i = 0; i < 95; i++)
            queue_request(3'($urandom_range(0, 7)), {rand_word(), rand_word()});
         wait_drained();
      end

      // Allow for any byte the block might still put out after the last expected one.
      repeat (16) @(posedge clock);
      @(negedge clock);
      if (expected_bytes.size() != 0) begin
         $error("%0d code bytes never arrived", expected_bytes.size());
         errors++;
      end
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: ends a hung run with a failure.
   initial begin
      #(12 * 250000);
      $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/u5ve_pkg.sv
rtl/u5ve_mode_map.sv
rtl/u5ve_word_coder.sv
rtl/u5ve_byte_sequencer.sv
rtl/unsigned5_varint_encoder_core.sv
rtl/u5ve_checker.sv
tb/tb.sv
